[rtl/lce_pkg.sv]
// ----------------------------------------------------------------------------
// Linear convolution engine package
// Shared constants, command codes and the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lce_pkg;

   localparam int MAX_TAPS    = 4096;
   localparam int SAMPLE_BITS = 24;
   localparam int TAP_ADDR_W  = $clog2(MAX_TAPS);
   localparam int FILL_W      = TAP_ADDR_W + 1;
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int ACC_W       = 64;
   localparam int VALUE_W     = 32;
   localparam int TAP_COUNT_W = 13;
   localparam int SHIFT_W     = 5;
   localparam int TAIL_W      = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CMD_W       = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TAIL   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAP_COUNT = 1'b0,
      CSR_OUT_SHIFT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  accept;
      logic                  issue;
      logic [TAP_ADDR_W-1:0] tap;
      logic                  shift;
      logic                  emit;
   } lce_ctl_type;

   typedef struct packed {
      logic [TAP_ADDR_W-1:0] last_tap;
      logic                  out_busy;
   } lce_stat_type;

endpackage

`default_nettype wire

[rtl/lce_ctrl.sv]
// ----------------------------------------------------------------------------
// Linear convolution engine controller
// Accepts command beats and sequences the tap walk, the pipeline drain,
// the output scaling and the hand-over to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire [lce_pkg::CMD_W-1:0]     req_command,
   output logic                         req_ready,
   input  lce_pkg::lce_stat_type        stat,
   output lce_pkg::lce_ctl_type         ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   state_type                           state_ff, state_in;
   logic [lce_pkg::TAP_ADDR_W-1:0]      tap_ff, tap_in;
   logic                                drain_ff, drain_in;
   logic                                accept;
   logic                                needs_output;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign needs_output = (lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_SAMPLE) ||
                         (lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_TAIL);

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      drain_in   = drain_ff;
      ctl.accept = accept;
      ctl.issue  = 1'b0;
      ctl.tap    = tap_ff;
      ctl.shift  = 1'b0;
      ctl.emit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            tap_in = '0;
            if (accept && needs_output) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.issue = 1'b1;
            if (tap_ff == stat.last_tap) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ctl.shift = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         drain_ff <= drain_in;
      end
   end

endmodule

`default_nettype wire

[rtl/lce_datapath.sv]
// ----------------------------------------------------------------------------
// Linear convolution engine datapath
// Holds the kernel and history memories, the pointers and counters, the
// configuration registers, the multiply-accumulate pipeline, the output
// scaling with rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_datapath (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire  [lce_pkg::CMD_W-1:0]                 req_command,
   input  wire  signed [lce_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  wire                                       csr_write,
   input  wire  [lce_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  wire  [lce_pkg::CSR_DATA_W-1:0]            csr_wdata,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output logic signed [lce_pkg::VALUE_W-1:0]        rsp_value,
   output logic                                      rsp_last,
   output logic                                      rsp_saturated,
   input  lce_pkg::lce_ctl_type                      ctl,
   output lce_pkg::lce_stat_type                     stat
);

   localparam int AW = lce_pkg::TAP_ADDR_W;
   localparam int FW = lce_pkg::FILL_W;
   localparam int SB = lce_pkg::SAMPLE_BITS;
   localparam int PW = lce_pkg::PROD_W;
   localparam int XW = lce_pkg::ACC_W;

   logic signed [SB-1:0]                   kernel_mem [lce_pkg::MAX_TAPS];
   logic signed [SB-1:0]                   history_mem [lce_pkg::MAX_TAPS];

   logic [lce_pkg::TAP_COUNT_W-1:0]        tap_count_ff;
   logic [lce_pkg::SHIFT_W-1:0]            out_shift_ff;
   logic [AW-1:0]                          pointer_ff, pointer_in;
   logic [FW-1:0]                          load_count_ff, load_count_in;
   logic [FW-1:0]                          fill_ff, fill_in;
   logic [lce_pkg::TAIL_W-1:0]             tail_ff, tail_in, tail_inc;
   logic                                   last_ff, last_in;

   logic signed [SB-1:0]                   kdata_ff;
   logic signed [SB-1:0]                   hdata_ff;
   logic                                   hzero_ff;
   logic                                   v1_ff;
   logic signed [PW-1:0]                   prod_ff;
   logic                                   v2_ff;
   logic [XW-1:0]                          acc_ff;
   logic signed [XW-1:0]                   shifted_ff;
   logic                                   round_bit_ff;

   logic signed [XW-1:0]                   rounded;
   logic signed [lce_pkg::VALUE_W-1:0]     clipped;
   logic                                   clip;

   logic                                   rsp_valid_ff;
   logic signed [lce_pkg::VALUE_W-1:0]     rsp_value_ff;
   logic                                   rsp_last_ff;
   logic                                   rsp_saturated_ff;

   lce_pkg::cmd_type                       cmd;
   logic                                   do_load;
   logic                                   do_push;
   logic [AW-1:0]                          push_addr;
   logic signed [SB-1:0]                   push_data;

   assign cmd       = lce_pkg::cmd_type'(req_command);
   assign do_load   = ctl.accept && (cmd == lce_pkg::CMD_LOAD) &&
                      (load_count_ff < FW'(lce_pkg::MAX_TAPS));
   assign do_push   = ctl.accept && ((cmd == lce_pkg::CMD_SAMPLE) ||
                                     (cmd == lce_pkg::CMD_TAIL));
   assign push_addr = pointer_ff + 1'b1;
   assign push_data = (cmd == lce_pkg::CMD_SAMPLE) ? req_sample : '0;
   assign tail_inc  = (tail_ff != '1) ? tail_ff + 1'b1 : tail_ff;

   // Effective tap count is clamped to one at the bottom and the store depth at the top.
   always_comb begin
      stat.out_busy = rsp_valid_ff && !rsp_ready;
      if (tap_count_ff <= lce_pkg::TAP_COUNT_W'(1)) begin
         stat.last_tap = '0;
      end else if (int'(tap_count_ff) > lce_pkg::MAX_TAPS) begin
         stat.last_tap = AW'(lce_pkg::MAX_TAPS - 1);
      end else begin
         stat.last_tap = AW'(tap_count_ff - 1'b1);
      end
   end

   always_comb begin
      pointer_in    = pointer_ff;
      load_count_in = load_count_ff;
      fill_in       = fill_ff;
      tail_in       = tail_ff;
      last_in       = last_ff;
      if (do_load) begin
         load_count_in = load_count_ff + 1'b1;
      end
      if (do_push) begin
         pointer_in = push_addr;
         if (fill_ff < FW'(lce_pkg::MAX_TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (ctl.accept) begin
         case (cmd)
            lce_pkg::CMD_SAMPLE: begin
               tail_in = '0;
               last_in = 1'b0;
            end
            lce_pkg::CMD_TAIL: begin
               tail_in = tail_inc;
               last_in = (tap_count_ff >= lce_pkg::TAP_COUNT_W'(2)) &&
                         (tail_inc == tap_count_ff - 1'b1);
            end
            lce_pkg::CMD_CLEAR: begin
               pointer_in    = '0;
               load_count_in = '0;
               fill_in       = '0;
               tail_in       = '0;
            end
            default: begin
               last_in = last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff  <= lce_pkg::TAP_COUNT_W'(1);
         out_shift_ff  <= '0;
         pointer_ff    <= '0;
         load_count_ff <= '0;
         fill_ff       <= '0;
         tail_ff       <= '0;
         last_ff       <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            case (lce_pkg::csr_index_type'(csr_index))
               lce_pkg::CSR_TAP_COUNT: tap_count_ff <= csr_wdata;
               lce_pkg::CSR_OUT_SHIFT: out_shift_ff <= lce_pkg::SHIFT_W'(csr_wdata);
               default:                tap_count_ff <= tap_count_ff;
            endcase
         end
         pointer_ff    <= pointer_in;
         load_count_ff <= load_count_in;
         fill_ff       <= fill_in;
         tail_ff       <= tail_in;
         last_ff       <= last_in;
         v1_ff         <= ctl.issue;
         v2_ff         <= v1_ff;
      end
   end

   // Memories: one write port each, registered read at the tap being walked.
   always_ff @(posedge clock) begin
      if (do_load) begin
         kernel_mem[load_count_ff[AW-1:0]] <= req_sample;
      end
      kdata_ff <= kernel_mem[ctl.tap];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         history_mem[push_addr] <= push_data;
      end
      hdata_ff <= history_mem[pointer_ff - ctl.tap];
   end

   // History entries older than the pushes since the last clear read as zero.
   always_ff @(posedge clock) begin
      hzero_ff <= ({1'b0, ctl.tap} >= fill_ff);
      prod_ff  <= kdata_ff * (hzero_ff ? SB'(0) : hdata_ff);
      if (do_push) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + {{(XW - PW){prod_ff[PW-1]}}, prod_ff};
      end
      if (ctl.shift) begin
         shifted_ff   <= $signed(acc_ff) >>> out_shift_ff;
         round_bit_ff <= (out_shift_ff != '0) ? acc_ff[out_shift_ff - 1'b1] : 1'b0;
      end
   end

   always_comb begin
      rounded = shifted_ff + XW'(round_bit_ff);
      clip    = 1'b0;
      clipped = rounded[lce_pkg::VALUE_W-1:0];
      if (rounded > XW'(64'sh0000_0000_7FFF_FFFF)) begin
         clip    = 1'b1;
         clipped = 32'sh7FFF_FFFF;
      end else if (rounded < $signed(64'hFFFF_FFFF_8000_0000)) begin
         clip    = 1'b1;
         clipped = 32'sh8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_value_ff     <= clipped;
         rsp_last_ff      <= last_ff;
         rsp_saturated_ff <= clip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

`default_nettype wire

[rtl/linear_convolution_engine.sv]
// ----------------------------------------------------------------------------
// Linear convolution engine
// Direct-form FIR that convolves a recording with a loaded inverse filter.
// ----------------------------------------------------------------------------
// Usage
// Command beats arrive on the req_ channel. A load beat writes the next
// kernel tap, a clear beat empties the history and counters; both leave
// the engine ready again and give no result. A sample beat shifts a
// sample into the history, a tail beat shifts in a zero; each gives one
// result beat on rsp_. One multiply-accumulate unit walks the taps, one
// per cycle, fed by the kernel and history memories through a registered
// read and a registered product; the engine then drains the pipeline,
// scales the sum and loads the result register. The result register
// frees the input side: the engine starts the next beat while a result
// waits, and holds only the final hand-over while the receiver stalls.
// Configuration is written through csr_ while idle. Synchronous reset
// clears the pointers, counters and result flag, so old history reads as
// zero; the kernel store holds undefined taps until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_convolution_engine (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire  [lce_pkg::CMD_W-1:0]                req_command,
   input  wire  signed [lce_pkg::SAMPLE_BITS-1:0]   req_sample,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic signed [lce_pkg::VALUE_W-1:0]       rsp_value,
   output logic                                     rsp_last,
   output logic                                     rsp_saturated,
   input  wire                                      csr_write,
   input  wire  [lce_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  wire  [lce_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   lce_pkg::lce_ctl_type   ctl;
   lce_pkg::lce_stat_type  stat;

   lce_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .stat        (stat),
      .ctl         (ctl)
   );

   lce_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_command),
      .req_sample    (req_sample),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last),
      .rsp_saturated (rsp_saturated),
      .ctl           (ctl),
      .stat          (stat)
   );

   // A beat that needs a result makes the engine busy on the next cycle.
   a_busy_after_output_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_SAMPLE) ||
       (lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_TAIL))
      |=> !req_ready)
      else $error("engine still ready after a sample or tail beat");

   // Load and clear beats leave the engine ready again on the next cycle.
   a_ready_after_quiet_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_LOAD) ||
       (lce_pkg::cmd_type'(req_command) == lce_pkg::CMD_CLEAR))
      |=> req_ready)
      else $error("engine busy after a load or clear beat");

   // A new result is handed over only as the controller returns to idle.
   a_result_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while the engine is busy");

   // A result raised with the final tail flag follows a busy engine cycle.
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_last |-> !$past(req_ready))
      else $error("last flag on a result without a computed tail beat");

endmodule

`default_nettype wire

[tb/sv/tb_linear_convolution_engine.sv]
// ----------------------------------------------------------------------------
// Linear convolution engine testbench
// Drives load, sample, tail and clear beats into the engine with bursty
// request timing and a stalling receiver, and keeps a direct-form
// convolution of its own for every output that a table row does not fix.
// A short table of hand-picked beats and register settings comes first, then
// random load-and-convolve sequences with stray commands mixed in.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_convolution_engine;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 105;
   localparam logic signed [63:0] VALUE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] VALUE_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [lce_pkg::VALUE_W-1:0] value;
      logic                        last;
      logic                        sat;
   } conv_out_type;

   typedef struct packed {
      logic                            is_reg;
      lce_pkg::csr_index_type          reg_idx;
      logic [lce_pkg::CSR_DATA_W-1:0]  reg_data;
      lce_pkg::cmd_type                cmd;
      logic [lce_pkg::SAMPLE_BITS-1:0] smp;
      logic                            known;
      conv_out_type                    want;
   } step_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [lce_pkg::CMD_W-1:0]              req_command = lce_pkg::CMD_LOAD;
   logic signed [lce_pkg::SAMPLE_BITS-1:0] req_sample = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [lce_pkg::VALUE_W-1:0]     rsp_value;
   logic                                   rsp_last;
   logic                                   rsp_saturated;
   logic                                   csr_write = 1'b0;
   logic [lce_pkg::CSR_INDEX_W-1:0]        csr_index = lce_pkg::CSR_TAP_COUNT;
   logic [lce_pkg::CSR_DATA_W-1:0]         csr_wdata = '0;

   logic signed [lce_pkg::SAMPLE_BITS-1:0] kernel_mem [lce_pkg::MAX_TAPS];
   logic signed [lce_pkg::SAMPLE_BITS-1:0] history_mem [lce_pkg::MAX_TAPS];
   int                                     hist_ptr;
   int                                     loads_taken;
   int                                     tails_seen;
   int                                     kernel_written = 0;
   logic [lce_pkg::CSR_DATA_W-1:0]         tap_count_reg = 13'd1;
   logic [4:0]                             out_shift_reg = 5'd0;

   conv_out_type                           pending_outputs [$];
   step_type                               plan [$];
   int                                     mismatch_count = 0;
   int                                     outputs_seen = 0;
   int                                     beats_taken = 0;
   int                                     burst_left = 0;
   int                                     cycle_count = 0;
   int                                     ready_left = 0;
   logic [15:0]                            ready_pattern = 16'hFFFF;

   linear_convolution_engine u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last),
      .rsp_saturated (rsp_saturated),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int active_taps();
      if (tap_count_reg == 0) return 1;
      if (int'(tap_count_reg) > lce_pkg::MAX_TAPS) return lce_pkg::MAX_TAPS;
      return int'(tap_count_reg);
   endfunction

   function automatic void clear_history();
      for (int k = 0; k < lce_pkg::MAX_TAPS; k++) history_mem[k] = '0;
      hist_ptr = 0;
      loads_taken = 0;
      tails_seen = 0;
   endfunction

   function automatic conv_out_type fir_output(logic last_flag);
      conv_out_type       res;
      logic signed [63:0] acc;
      logic signed [63:0] r;
      int                 sh;
      int                 idx;
      acc = '0;
      for (int k = 0; k < active_taps(); k++) begin
         idx = (hist_ptr + lce_pkg::MAX_TAPS - k) % lce_pkg::MAX_TAPS;
         acc = acc + kernel_mem[k] * history_mem[idx];
      end
      sh = int'(out_shift_reg);
      r = acc >>> sh;
      if (sh > 0) r = r + acc[sh-1];
      res.sat = 1'b0;
      if (r > VALUE_MAX) begin
         r = VALUE_MAX;
         res.sat = 1'b1;
      end else if (r < VALUE_MIN) begin
         r = VALUE_MIN;
         res.sat = 1'b1;
      end
      res.value = r[lce_pkg::VALUE_W-1:0];
      res.last = last_flag;
      return res;
   endfunction

   function automatic void take_command(lce_pkg::cmd_type cmd,
                                        logic [lce_pkg::SAMPLE_BITS-1:0] smp,
                                        logic known, conv_out_type want);
      conv_out_type got;
      case (cmd)
         lce_pkg::CMD_LOAD: begin
            if (loads_taken < lce_pkg::MAX_TAPS) begin
               kernel_mem[loads_taken] = smp;
               loads_taken++;
               if (loads_taken > kernel_written) kernel_written = loads_taken;
            end
         end
         lce_pkg::CMD_SAMPLE: begin
            tails_seen = 0;
            hist_ptr = (hist_ptr + 1) % lce_pkg::MAX_TAPS;
            history_mem[hist_ptr] = smp;
            got = fir_output(1'b0);
            pending_outputs.push_back(known ? want : got);
         end
         lce_pkg::CMD_TAIL: begin
            if (tails_seen < 8191) tails_seen++;
            hist_ptr = (hist_ptr + 1) % lce_pkg::MAX_TAPS;
            history_mem[hist_ptr] = '0;
            got = fir_output(tap_count_reg >= 2 && tails_seen == tap_count_reg - 1);
            pending_outputs.push_back(known ? want : got);
         end
         default: clear_history();
      endcase
   endfunction

   function automatic logic [lce_pkg::SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return lce_pkg::SAMPLE_BITS'($urandom_range(0, 255));
         3: return 24'hFFFFFF - lce_pkg::SAMPLE_BITS'($urandom_range(0, 255));
         default: return lce_pkg::SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] output %0d: %s is %h, expected %h",
               $realtime, outputs_seen, field, got, want);
      mismatch_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (active_taps() + 8) @(posedge clock);
   endtask

   task automatic write_reg(lce_pkg::csr_index_type idx,
                            logic [lce_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == lce_pkg::CSR_TAP_COUNT) tap_count_reg = data;
      else out_shift_reg = data[4:0];
   endtask

   task automatic put_beat(lce_pkg::cmd_type cmd, logic [lce_pkg::SAMPLE_BITS-1:0] smp,
                           logic known, conv_out_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_sample  <= smp;
      do @(posedge clock); while (!req_ready);
      beats_taken++;
      take_command(cmd, smp, known, want);
   endtask

   function automatic void add_reg(lce_pkg::csr_index_type idx,
                                   logic [lce_pkg::CSR_DATA_W-1:0] data);
      step_type row;
      row = '0;
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_data = data;
      plan.push_back(row);
   endfunction

   function automatic void add_beat(lce_pkg::cmd_type cmd,
                                    logic [lce_pkg::SAMPLE_BITS-1:0] smp);
      step_type row;
      row = '0;
      row.cmd = cmd;
      row.smp = smp;
      plan.push_back(row);
   endfunction

   function automatic void add_known(lce_pkg::cmd_type cmd,
                                     logic [lce_pkg::SAMPLE_BITS-1:0] smp,
                                     logic [lce_pkg::VALUE_W-1:0] value,
                                     logic last, logic sat);
      step_type row;
      row = '0;
      row.cmd = cmd;
      row.smp = smp;
      row.known = 1'b1;
      row.want.value = value;
      row.want.last = last;
      row.want.sat = sat;
      plan.push_back(row);
   endfunction

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_left = $urandom_range(16, 96);
         ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : (16'($urandom()) | 16'h0001);
      end
      ready_left--;
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      rsp_ready <= ready_pattern[0];
   end

   always @(posedge clock) begin : watch_results
      conv_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch("unexpected beat, value", rsp_value, '0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
         end
         outputs_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int start;
      int n_loads;
      int avail;
      int taps;
      int n_samples;
      int n_tails;

      clear_history();
      for (int k = 0; k < lce_pkg::MAX_TAPS; k++) kernel_mem[k] = '0;

      add_reg(lce_pkg::CSR_TAP_COUNT, 13'd1);
      add_reg(lce_pkg::CSR_OUT_SHIFT, 13'd0);
      add_beat(lce_pkg::CMD_LOAD, 24'h7FFFFF);
      add_known(lce_pkg::CMD_SAMPLE, 24'h7FFFFF, 32'h7FFFFFFF, 1'b0, 1'b1);
      add_known(lce_pkg::CMD_SAMPLE, 24'h800000, 32'h80000000, 1'b0, 1'b1);
      add_known(lce_pkg::CMD_TAIL, 24'h000000, 32'h00000000, 1'b0, 1'b0);
      add_known(lce_pkg::CMD_SAMPLE, 24'h000000, 32'h00000000, 1'b0, 1'b0);
      add_beat(lce_pkg::CMD_LOAD, 24'h800000);
      add_beat(lce_pkg::CMD_LOAD, 24'h000001);
      add_beat(lce_pkg::CMD_LOAD, 24'h400000);
      add_reg(lce_pkg::CSR_TAP_COUNT, 13'd4);
      add_reg(lce_pkg::CSR_OUT_SHIFT, 13'd23);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h000001);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h7FFFFF);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h800000);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_beat(lce_pkg::CMD_TAIL, 24'hFFFFFF);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_reg(lce_pkg::CSR_TAP_COUNT, 13'd2);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h123456);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_beat(lce_pkg::CMD_CLEAR, 24'hFFFFFF);
      add_reg(lce_pkg::CSR_TAP_COUNT, 13'd0);
      add_reg(lce_pkg::CSR_OUT_SHIFT, 13'd31);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h800000);
      add_beat(lce_pkg::CMD_TAIL, 24'h000000);
      add_beat(lce_pkg::CMD_LOAD, 24'h3FFFFF);
      add_beat(lce_pkg::CMD_SAMPLE, 24'h7FFFFF);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_data);
         else put_beat(plan[i].cmd, plan[i].smp, plan[i].known, plan[i].want);
      end

      start = beats_taken;
      while (beats_taken - start < RANDOM_ITEMS) begin
         n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
         avail = (n_loads > kernel_written) ? n_loads : kernel_written;
         taps = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, avail);
         write_reg(lce_pkg::CSR_TAP_COUNT, lce_pkg::CSR_DATA_W'(taps));
         write_reg(lce_pkg::CSR_OUT_SHIFT,
                   lce_pkg::CSR_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                                    : $urandom_range(14, 23)));
         put_beat(lce_pkg::CMD_CLEAR, rand_sample(), 1'b0, '0);
         repeat (n_loads) put_beat(lce_pkg::CMD_LOAD, rand_sample(), 1'b0, '0);
         n_samples = $urandom_range(1, 8);
         n_tails = ((taps > 1) ? taps - 1 : 0) + $urandom_range(0, 2);
         for (int i = 0; i < n_samples + n_tails; i++) begin
            if ($urandom_range(0, 9) == 0)
               put_beat(lce_pkg::cmd_type'($urandom_range(0, 3)), rand_sample(), 1'b0, '0);
            put_beat((i < n_samples) ? lce_pkg::CMD_SAMPLE : lce_pkg::CMD_TAIL,
                     rand_sample(), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_outputs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/lce_pkg.sv
rtl/lce_ctrl.sv
rtl/lce_datapath.sv
rtl/linear_convolution_engine.sv
tb/sv/tb_linear_convolution_engine.sv
